// ----- hdl/round_robin_task_scheduler_top_defines.svh -----
// assertion macros for the round-robin task scheduler
`ifndef ROUND_ROBIN_TASK_SCHEDULER_TOP_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// condition must hold at every edge out of reset
`define RRTS_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
		else $error("rrts assertion failed");
// antecedent implies consequent in the same cycle
`define RRTS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("rrts assertion failed");
// antecedent implies consequent in the next cycle
`define RRTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("rrts assertion failed");
`else
`define RRTS_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define RRTS_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define RRTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- hdl/rrts_pkg.sv -----
`default_nettype none

package rrts_pkg;

	localparam int SLOTS     = 16;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int USED_W    = $clog2(SLOTS + 1);
	localparam int CMD_W     = 3;
	localparam int STAT_W    = 2;
	localparam int QUANTUM_W = 16;

	localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(4);

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd2;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 3'd0,
		CMD_YIELD  = 3'd1,
		CMD_BLOCK  = 3'd2,
		CMD_EXIT   = 3'd3,
		CMD_WAKE   = 3'd4,
		CMD_CREATE = 3'd5,
		CMD_WAIT   = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DEAD  = 2'd0,
		ST_READY = 2'd1,
		ST_RUN   = 2'd2,
		ST_BLOCK = 2'd3
	} task_st_t;

	typedef struct packed {
		task_st_t          st;
		logic              wv;
		logic [SLOT_W-1:0] wo;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
		entry_t            wr_data;
	} tbl_req_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [SLOT_W-1:0] target_slot;
	} rrts_req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] running_slot;
		logic              switched;
		logic [SLOT_W-1:0] new_task;
		logic [STAT_W-1:0] status;
	} rrts_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SWP_RD,
		S_SWP_CHK,
		S_CUR_RD,
		S_CUR_CHK,
		S_TGT_RD,
		S_TGT_CHK,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_PICK_RD,
		S_PICK_WR
	} seq_state_t;

	// contents of a slot that was never written
	function automatic entry_t reset_entry(input logic [SLOT_W-1:0] addr);
		entry_t e;
		e.st = (addr == '0) ? ST_RUN : ST_DEAD;
		e.wv = 1'b0;
		e.wo = '0;
		return e;
	endfunction

	// round-robin successor inside the used part of the table
	function automatic logic [SLOT_W-1:0] wrap_next(input logic [SLOT_W-1:0] idx,
		input logic [USED_W-1:0] used);
		logic [USED_W-1:0] nx;
		nx = USED_W'(idx) + USED_W'(1);
		return (nx >= used) ? '0 : nx[SLOT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- hdl/round_robin_task_scheduler_top.sv -----
// channel   signals                         beat taken when
// --------  ------------------------------  --------------------------
// command   start, busy, req                start && !busy
// result    done, rsp                       done (one cycle, no stall)
// config    cfg_valid, cfg_ready, cfg_data  cfg_valid && cfg_ready
//
// the task table sits in one ram with registered read, so each table access is a
// read state and a check state; a tick that does not switch passes dispatch and one
// access of the running slot. a switch adds an access per slot examined (at most
// slots_used) and a write to mark the pick (after a read when it falls back to idle);
// exit adds an access per used slot above slot 0. asynchronous reset leaves slot 0
// running with no table clearing pass. results cannot be stalled; a new command may be taken in the result cycle.
`default_nettype none
`include "round_robin_task_scheduler_top_defines.svh"

module round_robin_task_scheduler_top
	import rrts_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output      logic                 busy,
	input  wire rrts_req_t            req,
	output      logic                 done,
	output      rrts_rsp_t            rsp,
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [QUANTUM_W-1:0] cfg_data
);

	logic [QUANTUM_W-1:0] quantum_q;
	logic [USED_W-1:0]    slots_used;
	tbl_req_t             tbl;
	entry_t               rd_entry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			quantum_q <= cfg_data;
		end
	end

	rrts_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.tbl     (tbl),
		.rd_entry(rd_entry)
	);

	rrts_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.quantum   (quantum_q),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp),
		.tbl       (tbl),
		.rd_entry  (rd_entry),
		.slots_used(slots_used)
	);

	`RRTS_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`RRTS_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`RRTS_ASSERT_SAME(a_run_in_use, clk, arst_n, done, USED_W'(rsp.running_slot) < slots_used)
	`RRTS_ASSERT_ALWAYS(a_used_range, clk, arst_n, slots_used != '0 && slots_used <= USED_W'(SLOTS))

endmodule

`default_nettype wire

// ----- hdl/rrts_ram.sv -----
`default_nettype none

module rrts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/rrts_table.sv -----
`default_nettype none

module rrts_table
	import rrts_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire tbl_req_t tbl,
	output      entry_t   rd_entry
);

	logic [SLOTS-1:0]   vld_q;
	logic               vld_s1;
	logic [SLOT_W-1:0]  raddr_s1;
	logic [ENTRY_W-1:0] ram_rdata;

	rrts_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (tbl.wr_en),
		.waddr(tbl.wr_addr),
		.wdata(tbl.wr_data),
		.re   (tbl.rd_en),
		.raddr(tbl.rd_addr),
		.rdata(ram_rdata)
	);

	// a slot reads as its reset contents until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (tbl.wr_en) begin
				vld_q[tbl.wr_addr] <= 1'b1;
			end
			if (tbl.rd_en) begin
				vld_s1 <= vld_q[tbl.rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tbl.rd_en) begin
			raddr_s1 <= tbl.rd_addr;
		end
	end

	assign rd_entry = vld_s1 ? entry_t'(ram_rdata) : reset_entry(raddr_s1);

endmodule

`default_nettype wire

// ----- hdl/rrts_seq.sv -----
`default_nettype none

module rrts_seq
	import rrts_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire rrts_req_t            req,
	input  wire logic [QUANTUM_W-1:0] quantum,
	output      logic                 busy,
	output      logic                 done,
	output      rrts_rsp_t            rsp,
	output      tbl_req_t             tbl,
	input  wire entry_t               rd_entry,
	output      logic [USED_W-1:0]    slots_used
);

	seq_state_t state_q, state_d;

	cmd_t                 cmd_q;
	logic [SLOT_W-1:0]    tgt_q;
	logic [SLOT_W-1:0]    cur_q, cur_d;
	logic [SLOT_W-1:0]    scan_q, scan_d;
	logic [USED_W-1:0]    used_q, used_d;
	logic [QUANTUM_W-1:0] slice_q, slice_d;
	logic [SLOT_W-1:0]    idx_q, idx_d;
	logic [USED_W-1:0]    cnt_q, cnt_d;
	logic [SLOT_W-1:0]    pick_q, pick_d;
	logic                 done_q;
	rrts_rsp_t            rsp_q;

	logic              fin;
	logic              fin_sw;
	logic [SLOT_W-1:0] fin_new;
	logic [STAT_W-1:0] fin_st;
	logic [SLOT_W-1:0] scan_first;
	logic              tgt_in_use;
	entry_t            e_mod;

	assign scan_first = (USED_W'(scan_q) < used_q) ? scan_q : '0;
	assign tgt_in_use = USED_W'(tgt_q) < used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q   <= '0;
			scan_q  <= '0;
			used_q  <= USED_W'(1);
			slice_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cur_q   <= cur_d;
			scan_q  <= scan_d;
			used_q  <= used_d;
			slice_q <= slice_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q <= cmd_t'(req.cmd);
			tgt_q <= req.target_slot;
		end
		idx_q  <= idx_d;
		cnt_q  <= cnt_d;
		pick_q <= pick_d;
		if (fin) begin
			rsp_q.running_slot <= cur_d;
			rsp_q.switched     <= fin_sw;
			rsp_q.new_task     <= fin_new;
			rsp_q.status       <= fin_st;
		end
	end

	always_comb begin
		state_d = state_q;
		cur_d   = cur_q;
		scan_d  = scan_q;
		used_d  = used_q;
		slice_d = slice_q;
		idx_d   = idx_q;
		cnt_d   = cnt_q;
		pick_d  = pick_q;
		fin     = 1'b0;
		fin_sw  = 1'b0;
		fin_new = '0;
		fin_st  = STAT_OK;
		tbl     = '0;
		e_mod   = rd_entry;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (cmd_q)
					CMD_TICK, CMD_YIELD, CMD_BLOCK: begin
						state_d = S_CUR_RD;
					end
					CMD_EXIT: begin
						idx_d   = SLOT_W'(1);
						state_d = (used_q > USED_W'(1)) ? S_SWP_RD : S_CUR_RD;
					end
					CMD_WAKE, CMD_WAIT: begin
						if (tgt_in_use) begin
							state_d = S_TGT_RD;
						end else begin
							fin     = 1'b1;
							fin_st  = (cmd_q == CMD_WAIT) ? STAT_ABSENT : STAT_OK;
							state_d = S_IDLE;
						end
					end
					CMD_CREATE: begin
						if (used_q < USED_W'(SLOTS)) begin
							tbl.wr_en      = 1'b1;
							tbl.wr_addr    = used_q[SLOT_W-1:0];
							tbl.wr_data.st = ST_READY;
							tbl.wr_data.wv = 1'b0;
							tbl.wr_data.wo = '0;
							used_d         = used_q + USED_W'(1);
							fin_new        = used_q[SLOT_W-1:0];
						end else begin
							fin_st = STAT_FULL;
						end
						fin     = 1'b1;
						state_d = S_IDLE;
					end
					default: begin
						fin     = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end
			// wake every task above slot 0 that is waiting on the exiting task
			S_SWP_RD: begin
				tbl.rd_en   = 1'b1;
				tbl.rd_addr = idx_q;
				state_d     = S_SWP_CHK;
			end
			S_SWP_CHK: begin
				if (idx_q != cur_q && rd_entry.wv && rd_entry.wo == cur_q) begin
					tbl.wr_en      = 1'b1;
					tbl.wr_addr    = idx_q;
					tbl.wr_data.st = ST_READY;
					tbl.wr_data.wv = 1'b0;
					tbl.wr_data.wo = rd_entry.wo;
				end
				if (USED_W'(idx_q) + USED_W'(1) >= used_q) begin
					state_d = S_CUR_RD;
				end else begin
					idx_d   = idx_q + SLOT_W'(1);
					state_d = S_SWP_RD;
				end
			end
			S_CUR_RD: begin
				tbl.rd_en   = 1'b1;
				tbl.rd_addr = cur_q;
				state_d     = S_CUR_CHK;
			end
			S_CUR_CHK: begin
				if (cmd_q == CMD_TICK && slice_q != '0 && rd_entry.st == ST_RUN) begin
					slice_d = slice_q - QUANTUM_W'(1);
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					// outgoing task, folded with the command's own update
					priority if (cmd_q == CMD_BLOCK) begin
						e_mod.st = ST_BLOCK;
					end else if (cmd_q == CMD_EXIT) begin
						e_mod.st = ST_DEAD;
						e_mod.wv = 1'b0;
					end else if (rd_entry.st == ST_RUN) begin
						e_mod.st = ST_READY;
						e_mod.wv = 1'b0;
					end else if (rd_entry.st == ST_DEAD) begin
						e_mod.wv = 1'b0;
					end
					tbl.wr_en   = 1'b1;
					tbl.wr_addr = cur_q;
					tbl.wr_data = e_mod;
					idx_d       = scan_first;
					cnt_d       = '0;
					state_d     = S_SCAN_RD;
				end
			end
			S_TGT_RD: begin
				tbl.rd_en   = 1'b1;
				tbl.rd_addr = tgt_q;
				state_d     = S_TGT_CHK;
			end
			S_TGT_CHK: begin
				if (cmd_q == CMD_WAKE) begin
					if (rd_entry.st != ST_DEAD && rd_entry.st != ST_RUN) begin
						tbl.wr_en      = 1'b1;
						tbl.wr_addr    = tgt_q;
						tbl.wr_data.st = ST_READY;
						tbl.wr_data.wv = rd_entry.wv;
						tbl.wr_data.wo = rd_entry.wo;
					end
					fin     = 1'b1;
					state_d = S_IDLE;
				end else if (rd_entry.st == ST_DEAD) begin
					fin     = 1'b1;
					fin_st  = STAT_ABSENT;
					state_d = S_IDLE;
				end else begin
					tbl.wr_en      = 1'b1;
					tbl.wr_addr    = cur_q;
					tbl.wr_data.st = ST_BLOCK;
					tbl.wr_data.wv = 1'b1;
					tbl.wr_data.wo = tgt_q;
					idx_d          = scan_first;
					cnt_d          = '0;
					state_d        = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				tbl.rd_en   = 1'b1;
				tbl.rd_addr = idx_q;
				state_d     = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (idx_q != '0 && rd_entry.st == ST_READY) begin
					pick_d  = idx_q;
					state_d = S_PICK_WR;
				end else if (cnt_q + USED_W'(1) >= used_q) begin
					// nothing ready: fall back to idle
					pick_d  = '0;
					state_d = S_PICK_RD;
				end else begin
					cnt_d   = cnt_q + USED_W'(1);
					idx_d   = wrap_next(idx_q, used_q);
					state_d = S_SCAN_RD;
				end
			end
			S_PICK_RD: begin
				tbl.rd_en   = 1'b1;
				tbl.rd_addr = pick_q;
				state_d     = S_PICK_WR;
			end
			S_PICK_WR: begin
				tbl.wr_en      = 1'b1;
				tbl.wr_addr    = pick_q;
				tbl.wr_data.st = ST_RUN;
				tbl.wr_data.wv = rd_entry.wv;
				tbl.wr_data.wo = rd_entry.wo;
				cur_d          = pick_q;
				scan_d         = wrap_next(pick_q, used_q);
				slice_d        = quantum;
				fin            = 1'b1;
				fin_sw         = 1'b1;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy       = state_q != S_IDLE;
	assign done       = done_q;
	assign rsp        = rsp_q;
	assign slots_used = used_q;

endmodule

`default_nettype wire
